FILE: src/cqtc_pkg.sv
package cqtc_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned PROC_W  = 32;
  localparam int unsigned TOTAL_W = 4;
  localparam int unsigned ENTRY_W = TYPE_W + PROC_W;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_CLR   = 3'd2,
    OP_PEEK  = 3'd3,
    OP_COUNT = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEQ   = 3'd0,
    KIND_FRONT = 3'd1,
    KIND_MATCH = 3'd2,
    KIND_TOTAL = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_FULL  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_PEEK,
    ST_SCAN,
    ST_TOTAL
  } state_e;

  typedef struct packed {
    logic  latch_type;
    logic  wr_en;
    logic  clr;
    logic  deq_adv;
    logic  scan_load;
    logic  scan_step;
    logic  raddr_scan;
    logic  out_load;
    kind_e out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
    logic hit;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

FILE: src/circular_queue_with_type_count.sv
// Enqueue, clear and any error answer leave busy low; an error result is strobed the next cycle.
// Dequeue and peek go busy in their own state, where the entry read through the entry store's
// registered read port is loaded into the result register; no new transaction is taken while busy.
// Count on a non-empty queue stays busy through a scan state and a total state, reading one
// entry per cycle from head to tail; on an empty queue it answers like an error and stays idle.
// Reset is asynchronous and clears the indices, occupancy, controller and result strobe.
// Stored entries are not cleared; the receiver cannot stall the result strobe.
module circular_queue_with_type_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [cqtc_pkg::OP_W-1:0]     op_i,
  input  logic [cqtc_pkg::TYPE_W-1:0]   entry_type_i,
  input  logic [cqtc_pkg::PROC_W-1:0]   entry_process_i,
  output logic                          valid_o,
  output logic [cqtc_pkg::KIND_W-1:0]   kind_o,
  output logic [cqtc_pkg::TYPE_W-1:0]   out_type_o,
  output logic [cqtc_pkg::PROC_W-1:0]   out_process_o,
  output logic [cqtc_pkg::TOTAL_W-1:0]  match_total_o,
  output logic                          last_o
);

  cqtc_pkg::dp_cmd_t    cmd;
  cqtc_pkg::dp_status_t status;

  cqtc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  cqtc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_type_i    (entry_type_i),
    .entry_process_i (entry_process_i),
    .valid_o         (valid_o),
    .kind_o          (kind_o),
    .out_type_o      (out_type_o),
    .out_process_o   (out_process_o),
    .match_total_o   (match_total_o),
    .last_o          (last_o)
  );

endmodule

FILE: src/cqtc_ram.sv
module cqtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cqtc_datapath.sv
module cqtc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cqtc_pkg::dp_cmd_t             cmd_i,
  output cqtc_pkg::dp_status_t          status_o,
  input  logic [cqtc_pkg::TYPE_W-1:0]   entry_type_i,
  input  logic [cqtc_pkg::PROC_W-1:0]   entry_process_i,
  output logic                          valid_o,
  output logic [cqtc_pkg::KIND_W-1:0]   kind_o,
  output logic [cqtc_pkg::TYPE_W-1:0]   out_type_o,
  output logic [cqtc_pkg::PROC_W-1:0]   out_process_o,
  output logic [cqtc_pkg::TOTAL_W-1:0]  match_total_o,
  output logic                          last_o
);

  logic [cqtc_pkg::IDX_W-1:0]   head_q, head_d;
  logic [cqtc_pkg::IDX_W-1:0]   tail_q, tail_d;
  logic [cqtc_pkg::CNT_W-1:0]   occ_q, occ_d;
  logic [cqtc_pkg::IDX_W-1:0]   scan_q, scan_d;
  logic [cqtc_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [cqtc_pkg::CNT_W-1:0]   match_q, match_d;
  logic [cqtc_pkg::TYPE_W-1:0]  type_q, type_d;
  logic                         valid_q;
  logic [cqtc_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [cqtc_pkg::TYPE_W-1:0]  otype_q, otype_d;
  logic [cqtc_pkg::PROC_W-1:0]  oproc_q, oproc_d;
  logic [cqtc_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                         last_q, last_d;
  logic [cqtc_pkg::IDX_W-1:0]   raddr;
  logic [cqtc_pkg::ENTRY_W-1:0] rdata;
  logic [cqtc_pkg::TYPE_W-1:0]  rd_type;
  logic [cqtc_pkg::PROC_W-1:0]  rd_proc;
  logic [31:0]                  match_wide;

  assign raddr   = cmd_i.raddr_scan ? cqtc_pkg::next_idx(scan_q) : head_q;
  assign rd_type = rdata[cqtc_pkg::ENTRY_W-1 -: cqtc_pkg::TYPE_W];
  assign rd_proc = rdata[cqtc_pkg::PROC_W-1:0];

  cqtc_ram #(
    .WIDTH (cqtc_pkg::ENTRY_W),
    .DEPTH (cqtc_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (tail_q),
    .wdata_i ({entry_type_i, entry_process_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign status_o.empty     = (occ_q == '0);
  assign status_o.full      = (occ_q == cqtc_pkg::CNT_W'(cqtc_pkg::DEPTH));
  assign status_o.scan_last = (rem_q == cqtc_pkg::CNT_W'(1));
  assign status_o.hit       = (rd_type == type_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (cmd_i.clr) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end else if (cmd_i.wr_en) begin
      tail_d = cqtc_pkg::next_idx(tail_q);
      occ_d  = occ_q + 1'b1;
    end else if (cmd_i.deq_adv) begin
      head_d = cqtc_pkg::next_idx(head_q);
      occ_d  = occ_q - 1'b1;
    end
  end

  always_comb begin
    type_d  = cmd_i.latch_type ? entry_type_i : type_q;
    scan_d  = scan_q;
    rem_d   = rem_q;
    match_d = match_q;
    if (cmd_i.scan_load) begin
      scan_d  = head_q;
      rem_d   = occ_q;
      match_d = '0;
    end else if (cmd_i.scan_step) begin
      scan_d = cqtc_pkg::next_idx(scan_q);
      rem_d  = rem_q - 1'b1;
      if (status_o.hit) begin
        match_d = match_q + 1'b1;
      end
    end
  end

  assign match_wide = 32'(match_d);

  always_comb begin
    kind_d  = cmd_i.out_kind;
    otype_d = '0;
    oproc_d = '0;
    total_d = '0;
    last_d  = (cmd_i.out_kind != cqtc_pkg::KIND_MATCH);
    case (cmd_i.out_kind)
      cqtc_pkg::KIND_DEQ, cqtc_pkg::KIND_FRONT, cqtc_pkg::KIND_MATCH: begin
        otype_d = rd_type;
        oproc_d = rd_proc;
      end
      cqtc_pkg::KIND_TOTAL: begin
        otype_d = type_d;
        total_d = match_wide[cqtc_pkg::TOTAL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      valid_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    scan_q  <= scan_d;
    rem_q   <= rem_d;
    match_q <= match_d;
    if (cmd_i.out_load) begin
      kind_q  <= kind_d;
      otype_q <= otype_d;
      oproc_q <= oproc_d;
      total_q <= total_d;
      last_q  <= last_d;
    end
  end

  assign valid_o       = valid_q;
  assign kind_o        = kind_q;
  assign out_type_o    = otype_q;
  assign out_process_o = oproc_q;
  assign match_total_o = total_q;
  assign last_o        = last_q;

endmodule

FILE: src/cqtc_ctrl.sv
module cqtc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [cqtc_pkg::OP_W-1:0]   op_i,
  input  cqtc_pkg::dp_status_t        status_i,
  output cqtc_pkg::dp_cmd_t           cmd_o,
  output logic                        busy
);

  cqtc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cqtc_pkg::ST_IDLE: begin
        if (start && !status_i.empty) begin
          case (op_i)
            cqtc_pkg::OP_DEQ:   state_d = cqtc_pkg::ST_DEQ;
            cqtc_pkg::OP_PEEK:  state_d = cqtc_pkg::ST_PEEK;
            cqtc_pkg::OP_COUNT: state_d = cqtc_pkg::ST_SCAN;
            default:            state_d = cqtc_pkg::ST_IDLE;
          endcase
        end
      end
      cqtc_pkg::ST_DEQ, cqtc_pkg::ST_PEEK: state_d = cqtc_pkg::ST_IDLE;
      cqtc_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = cqtc_pkg::ST_TOTAL;
        end
      end
      cqtc_pkg::ST_TOTAL: state_d = cqtc_pkg::ST_IDLE;
      default:            state_d = cqtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = cqtc_pkg::KIND_EMPTY;
    case (state_q)
      cqtc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.latch_type = 1'b1;
          case (op_i)
            cqtc_pkg::OP_ENQ: begin
              if (status_i.full) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = cqtc_pkg::KIND_FULL;
              end else begin
                cmd_o.wr_en = 1'b1;
              end
            end
            cqtc_pkg::OP_DEQ, cqtc_pkg::OP_PEEK: begin
              if (status_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = cqtc_pkg::KIND_EMPTY;
              end
            end
            cqtc_pkg::OP_CLR: cmd_o.clr = 1'b1;
            cqtc_pkg::OP_COUNT: begin
              cmd_o.scan_load = 1'b1;
              if (status_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = cqtc_pkg::KIND_TOTAL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cqtc_pkg::ST_DEQ: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = cqtc_pkg::KIND_DEQ;
        cmd_o.deq_adv  = 1'b1;
      end
      cqtc_pkg::ST_PEEK: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = cqtc_pkg::KIND_FRONT;
      end
      cqtc_pkg::ST_SCAN: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.raddr_scan = 1'b1;
        cmd_o.out_load   = status_i.hit;
        cmd_o.out_kind   = cqtc_pkg::KIND_MATCH;
      end
      cqtc_pkg::ST_TOTAL: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_kind = cqtc_pkg::KIND_TOTAL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != cqtc_pkg::ST_IDLE);

endmodule

FILE: src/cqtc_checker.sv
module cqtc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_o,
  input logic [cqtc_pkg::KIND_W-1:0]   kind_o,
  input logic [cqtc_pkg::TYPE_W-1:0]   out_type_o,
  input logic [cqtc_pkg::PROC_W-1:0]   out_process_o,
  input logic [cqtc_pkg::TOTAL_W-1:0]  match_total_o,
  input logic                          last_o
);

  // Only a matching entry of a count may be followed by more results of the same transaction.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o == (kind_o != cqtc_pkg::KIND_MATCH)))
    else $error("last flag does not match result kind");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (kind_o == cqtc_pkg::KIND_EMPTY || kind_o == cqtc_pkg::KIND_FULL)
    |-> (out_type_o == '0 && out_process_o == '0 && match_total_o == '0))
    else $error("error result carries data");

  a_total_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != cqtc_pkg::KIND_TOTAL |-> match_total_o == '0)
    else $error("match total set outside a count total");

  // A result in the cycle after a match can only belong to the same scan.
  a_match_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == cqtc_pkg::KIND_MATCH |=> !valid_o ||
    (kind_o == cqtc_pkg::KIND_MATCH || kind_o == cqtc_pkg::KIND_TOTAL))
    else $error("scan result sequence broken");

endmodule

bind circular_queue_with_type_count cqtc_checker u_cqtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_o       (valid_o),
  .kind_o        (kind_o),
  .out_type_o    (out_type_o),
  .out_process_o (out_process_o),
  .match_total_o (match_total_o),
  .last_o        (last_o)
);
